### hdl/mqttdf_pkg.sv
// Shared types and constants for the MQTT control packet deframer.
// Holds byte role and status codes, the config and result beat structs.
// No dependencies.
package mqttdf_pkg;

    // Remaining-length ceiling of the hardware, and length field size
    localparam int unsigned BODY_LIMIT       = 2048;
    localparam int unsigned LENGTH_BYTES_MAX = 4;

    localparam int unsigned BODY_LEN_W  = 12;
    localparam int unsigned TOPIC_MAX_W = 11;
    localparam int unsigned REM_LEN_W   = 28;

    localparam logic [3:0] TYPE_PUBLISH = 4'd3;

    // Byte roles
    localparam logic [2:0] ROLE_HEADER    = 3'd0;
    localparam logic [2:0] ROLE_LENGTH    = 3'd1;
    localparam logic [2:0] ROLE_TOPIC_LEN = 3'd2;
    localparam logic [2:0] ROLE_TOPIC     = 3'd3;
    localparam logic [2:0] ROLE_PACKET_ID = 3'd4;
    localparam logic [2:0] ROLE_BODY      = 3'd5;

    // Frame errors
    localparam logic [1:0] FERR_NONE     = 2'd0;
    localparam logic [1:0] FERR_OVERRUN  = 2'd1;
    localparam logic [1:0] FERR_TOO_LONG = 2'd2;

    // Publish verdicts
    localparam logic [2:0] PUB_NONE        = 3'd0;
    localparam logic [2:0] PUB_DELIVER     = 3'd1;
    localparam logic [2:0] PUB_PUBACK      = 3'd2;
    localparam logic [2:0] PUB_UNSUPPORTED = 3'd3;
    localparam logic [2:0] PUB_MALFORMED   = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MAX_BODY  = 1'b0;
    localparam logic CFG_MAX_TOPIC = 1'b1;

    typedef struct packed {
        logic [BODY_LEN_W-1:0]  max_body_length;
        logic [TOPIC_MAX_W-1:0] max_topic_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [2:0]  byte_role;
        logic [3:0]  packet_type;
        logic [3:0]  header_flags;
        logic [10:0] body_index;
        logic [11:0] body_length;
        logic        packet_done;
        logic [1:0]  frame_error;
        logic [1:0]  publish_qos;
        logic [15:0] publish_topic_length;
        logic [15:0] packet_identifier;
        logic [2:0]  publish_status;
    } t_result;

endpackage

### hdl/mqttdf_parse.sv
// Parser core of the MQTT deframer: per-byte packet state and result logic.
// Depends on mqttdf_pkg.
module mqttdf_parse
    import mqttdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    typedef enum logic [1:0] {
        ST_HEADER = 2'd0,
        ST_LENGTH = 2'd1,
        ST_BODY   = 2'd2
    } t_stage;

    t_stage                 r_stage, n_stage;
    logic [7:0]             r_hdr, n_hdr;
    logic [REM_LEN_W-1:0]   r_rem, n_rem;
    logic [2:0]             r_len_cnt, n_len_cnt;
    logic [BODY_LEN_W-1:0]  r_body_cnt, n_body_cnt;
    logic [15:0]            r_tl, n_tl;
    logic [15:0]            r_pid, n_pid;

    logic [BODY_LEN_W-1:0]  lim;
    logic [REM_LEN_W-1:0]   len_add;
    logic [17:0]            tend;
    logic [17:0]            idx_ext;
    logic [1:0]             hdr_qos;
    logic                   hdr_pub;
    logic                   is_pub;
    logic [1:0]             qos;
    logic [2:0]             role;
    logic [10:0]            index;
    logic [11:0]            blen;
    logic                   done;
    logic [1:0]             ferr;
    logic [2:0]             status;
    logic [11:0]            vlen;
    logic [16:0]            tl_ext;

    always_comb begin
        lim = (i_cfg.max_body_length < BODY_LEN_W'(BODY_LIMIT)) ?
              i_cfg.max_body_length : BODY_LEN_W'(BODY_LIMIT);
    end

    // Position the 7-bit group by length byte number
    always_comb begin
        case (r_len_cnt[1:0])
            2'd0:    len_add = {21'd0, i_byte[6:0]};
            2'd1:    len_add = {14'd0, i_byte[6:0], 7'd0};
            2'd2:    len_add = {7'd0, i_byte[6:0], 14'd0};
            default: len_add = {i_byte[6:0], 21'd0};
        endcase
    end

    assign hdr_pub = (r_hdr[7:4] == TYPE_PUBLISH);
    assign hdr_qos = r_hdr[2:1];
    assign tend    = 18'(r_tl) + 18'd2;
    assign idx_ext = 18'(r_body_cnt);

    always_comb begin
        n_stage    = r_stage;
        n_hdr      = r_hdr;
        n_rem      = r_rem;
        n_len_cnt  = r_len_cnt;
        n_body_cnt = r_body_cnt;
        n_tl       = r_tl;
        n_pid      = r_pid;
        role       = ROLE_HEADER;
        index      = 11'd0;
        blen       = 12'd0;
        done       = 1'b0;
        ferr       = FERR_NONE;

        unique case (r_stage)
            ST_LENGTH: begin
                role      = ROLE_LENGTH;
                n_rem     = r_rem + len_add;
                n_len_cnt = r_len_cnt + 3'd1;
                if (i_byte[7]) begin
                    if (n_len_cnt >= 3'(LENGTH_BYTES_MAX)) begin
                        ferr = FERR_OVERRUN;
                    end
                end else if (n_rem > REM_LEN_W'(lim)) begin
                    ferr = FERR_TOO_LONG;
                end else begin
                    blen = n_rem[11:0];
                    if (n_rem == '0) begin
                        done = 1'b1;
                    end else begin
                        n_stage = ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                role  = ROLE_BODY;
                index = r_body_cnt[10:0];
                blen  = r_rem[11:0];
                if (hdr_pub) begin
                    if (r_body_cnt == 12'd0) begin
                        role = ROLE_TOPIC_LEN;
                        n_tl = {i_byte, 8'd0};
                    end else if (r_body_cnt == 12'd1) begin
                        role = ROLE_TOPIC_LEN;
                        n_tl = {r_tl[15:8], i_byte};
                    end else if (idx_ext < tend) begin
                        role = ROLE_TOPIC;
                    end else if (hdr_qos != 2'd0 && idx_ext == tend) begin
                        role  = ROLE_PACKET_ID;
                        n_pid = {i_byte, 8'd0};
                    end else if (hdr_qos != 2'd0 && idx_ext == tend + 18'd1) begin
                        role  = ROLE_PACKET_ID;
                        n_pid = {r_pid[15:8], i_byte};
                    end
                end
                n_body_cnt = r_body_cnt + 12'd1;
                if (REM_LEN_W'(n_body_cnt) >= r_rem) begin
                    done = 1'b1;
                end
            end
            default: begin
                n_stage    = ST_LENGTH;
                n_hdr      = i_byte;
                n_rem      = '0;
                n_len_cnt  = 3'd0;
                n_body_cnt = '0;
                n_tl       = 16'd0;
                n_pid      = 16'd0;
            end
        endcase
    end

    // Publish verdict on the updated fields
    assign is_pub = (n_hdr[7:4] == TYPE_PUBLISH);
    assign qos    = is_pub ? n_hdr[2:1] : 2'd0;
    assign vlen   = n_rem[11:0];
    assign tl_ext = 17'(n_tl);

    always_comb begin
        status = PUB_NONE;
        if (done && is_pub) begin
            if (vlen < 12'd2) begin
                status = PUB_MALFORMED;
            end else if (tl_ext > 17'(vlen - 12'd2) ||
                         n_tl > 16'(i_cfg.max_topic_length)) begin
                status = PUB_MALFORMED;
            end else if (qos != 2'd0 && tl_ext + 17'd4 > 17'(vlen)) begin
                status = PUB_MALFORMED;
            end else if (qos == 2'd0) begin
                status = PUB_DELIVER;
            end else if (qos == 2'd1) begin
                status = (n_pid != 16'd0) ? PUB_PUBACK : PUB_DELIVER;
            end else begin
                status = PUB_UNSUPPORTED;
            end
        end
    end

    always_comb begin
        o_result.data_byte            = i_byte;
        o_result.byte_role            = role;
        o_result.packet_type          = n_hdr[7:4];
        o_result.header_flags         = n_hdr[3:0];
        o_result.body_index           = index;
        o_result.body_length          = blen;
        o_result.packet_done          = done;
        o_result.frame_error          = ferr;
        o_result.publish_qos          = qos;
        o_result.publish_topic_length = is_pub ? n_tl : 16'd0;
        o_result.packet_identifier    = (is_pub && qos != 2'd0) ? n_pid : 16'd0;
        o_result.publish_status       = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage    <= ST_HEADER;
            r_hdr      <= 8'd0;
            r_rem      <= '0;
            r_len_cnt  <= 3'd0;
            r_body_cnt <= '0;
            r_tl       <= 16'd0;
            r_pid      <= 16'd0;
        end else if (i_en) begin
            if (done || ferr != FERR_NONE) begin
                // Packet closed or dropped: wait for the next header
                r_stage    <= ST_HEADER;
                r_hdr      <= 8'd0;
                r_rem      <= '0;
                r_len_cnt  <= 3'd0;
                r_body_cnt <= '0;
                r_tl       <= 16'd0;
                r_pid      <= 16'd0;
            end else begin
                r_stage    <= n_stage;
                r_hdr      <= n_hdr;
                r_rem      <= n_rem;
                r_len_cnt  <= n_len_cnt;
                r_body_cnt <= n_body_cnt;
                r_tl       <= n_tl;
                r_pid      <= n_pid;
            end
        end
    end

endmodule

### hdl/mqtt_control_packet_deframer.sv
// Top level of the MQTT control packet deframer: input register, config
// registers, parser core and result register. Depends on mqttdf_pkg, mqttdf_parse.
//
// Usage: received bytes enter on i_rx_byte with i_valid; the block raises
// o_stall when it cannot take a beat. Each byte gives exactly one result beat
// on o_valid, held until the receiver takes it with i_stall low.
// Result: the byte echoed with its role, header nibbles, body index and
// length, end-of-packet flag, frame error and PUBLISH fields and verdict.
// The result beat is registered: its byte passes the input register, then the
// result register. Throughput: one byte per cycle while the receiver does not
// stall, set by the combinational parser update between the two registers.
// When the receiver stalls, the result register holds, then the input register
// fills, then o_stall rises; no beat is lost. Reset (synchronous, active low)
// empties both registers, returns the parser to awaiting a header and loads
// max_body_length 2048, max_topic_length 96. Configuration: i_cfg_we writes
// i_cfg_data into register i_cfg_index (0 max_body_length, 1 max_topic_length);
// the user writes only while the block is idle, which the block does not enforce.
module mqtt_control_packet_deframer
    import mqttdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_byte_role,
    output logic [3:0]  o_packet_type,
    output logic [3:0]  o_header_flags,
    output logic [10:0] o_body_index,
    output logic [11:0] o_body_length,
    output logic        o_packet_done,
    output logic [1:0]  o_frame_error,
    output logic [1:0]  o_publish_qos,
    output logic [15:0] o_publish_topic_length,
    output logic [15:0] o_packet_identifier,
    output logic [2:0]  o_publish_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;
    t_result    parse_res;
    logic       out_free;
    logic       advance;
    logic       in_free;

    assign out_free = !r_out_vld || !i_stall;
    assign advance  = r_in_vld && out_free;
    assign in_free  = !r_in_vld || out_free;
    assign o_stall  = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_body_length  <= BODY_LEN_W'(2048);
            r_cfg.max_topic_length <= TOPIC_MAX_W'(96);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_BODY:  r_cfg.max_body_length  <= i_cfg_data;
                CFG_MAX_TOPIC: r_cfg.max_topic_length <= i_cfg_data[TOPIC_MAX_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_free) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    mqttdf_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= parse_res;
        end
    end

    assign o_valid                = r_out_vld;
    assign o_data_byte            = r_out.data_byte;
    assign o_byte_role            = r_out.byte_role;
    assign o_packet_type          = r_out.packet_type;
    assign o_header_flags         = r_out.header_flags;
    assign o_body_index           = r_out.body_index;
    assign o_body_length          = r_out.body_length;
    assign o_packet_done          = r_out.packet_done;
    assign o_frame_error          = r_out.frame_error;
    assign o_publish_qos          = r_out.publish_qos;
    assign o_publish_topic_length = r_out.publish_topic_length;
    assign o_packet_identifier    = r_out.packet_identifier;
    assign o_publish_status       = r_out.publish_status;

endmodule

### verif/mqtt_control_packet_deframer_test.sv
// Self-checking testbench for mqtt_control_packet_deframer: drives MQTT byte streams
// under random valid/stall pacing and checks every result beat against a local parser.
// Depends on mqttdf_pkg and the deframer RTL.
module mqtt_control_packet_deframer_test;
    import mqttdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400_000;

    typedef enum logic [1:0] {
        AWAIT_HEADER = 2'd0,
        IN_LENGTH    = 2'd1,
        IN_BODY      = 2'd2
    } parse_stage_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_byte_role;
    logic [3:0]  o_packet_type;
    logic [3:0]  o_header_flags;
    logic [10:0] o_body_index;
    logic [11:0] o_body_length;
    logic        o_packet_done;
    logic [1:0]  o_frame_error;
    logic [1:0]  o_publish_qos;
    logic [15:0] o_publish_topic_length;
    logic [15:0] o_packet_identifier;
    logic [2:0]  o_publish_status;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_MAX_BODY;
    logic [11:0] i_cfg_data = 12'd0;

    mqtt_control_packet_deframer dut (.*);

    // Parser mirror and its copy of the registers
    parse_stage_e pstage;
    logic [7:0]   hdr_latch;
    logic [27:0]  rem_len;
    logic [2:0]   len_bytes;
    logic [11:0]  body_pos;
    logic [15:0]  tpc_size;
    logic [15:0]  pkt_id;
    logic [11:0]  cfg_body_max = 12'd2048;
    logic [10:0]  cfg_topic_max = 11'd96;

    logic [7:0]   tx_bytes[$];
    t_result      pending_beats[$];
    logic         tx_fire = 1'b0;
    logic         rx_fire = 1'b0;
    int unsigned  tx_wait = 0;
    int unsigned  rx_wait = 0;
    logic [1:0]   tx_pace = 2'd1;
    logic [1:0]   rx_pace = 2'd1;
    int unsigned  tx_sent = 0;
    int unsigned  rx_taken = 0;
    int unsigned  bytes_queued = 0;

    int unsigned  cycle_count = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  bytes_taken = 0;
    int unsigned  packets_closed = 0;
    int unsigned  frame_errors = 0;
    int unsigned  verdict_hits[5] = '{0, 0, 0, 0, 0};

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        pstage    = AWAIT_HEADER;
        hdr_latch = 8'h00;
        rem_len   = '0;
        len_bytes = '0;
        body_pos  = '0;
        tpc_size  = '0;
        pkt_id    = '0;
    endfunction

    // Advance the parser mirror by one byte and return the beat it should produce
    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result     r;
        logic [11:0] lim;
        logic        is_pub;
        int unsigned tend;
        r = '0;
        r.data_byte      = b;
        r.byte_role      = ROLE_HEADER;
        r.frame_error    = FERR_NONE;
        r.publish_status = PUB_NONE;
        lim = (cfg_body_max < BODY_LIMIT) ? cfg_body_max : BODY_LIMIT[11:0];
        case (pstage)
            IN_LENGTH: begin
                r.byte_role = ROLE_LENGTH;
                rem_len   = rem_len + (28'(b[6:0]) << (7 * len_bytes[1:0]));
                len_bytes = len_bytes + 3'd1;
                if (b[7]) begin
                    if (len_bytes >= LENGTH_BYTES_MAX)
                        r.frame_error = FERR_OVERRUN;
                end else if (rem_len > lim) begin
                    r.frame_error = FERR_TOO_LONG;
                end else begin
                    r.body_length = rem_len[11:0];
                    if (rem_len == 0)
                        r.packet_done = 1'b1;
                    else
                        pstage = IN_BODY;
                end
            end
            IN_BODY: begin
                r.byte_role   = ROLE_BODY;
                r.body_index  = body_pos[10:0];
                r.body_length = rem_len[11:0];
                if (hdr_latch[7:4] == TYPE_PUBLISH) begin
                    tend = 2 + tpc_size;
                    if (body_pos == 0) begin
                        r.byte_role = ROLE_TOPIC_LEN;
                        tpc_size = {b, 8'h00};
                    end else if (body_pos == 1) begin
                        r.byte_role = ROLE_TOPIC_LEN;
                        tpc_size = tpc_size | 16'(b);
                    end else if (body_pos < tend) begin
                        r.byte_role = ROLE_TOPIC;
                    end else if (hdr_latch[2:1] != 0 && body_pos == tend) begin
                        r.byte_role = ROLE_PACKET_ID;
                        pkt_id = {b, 8'h00};
                    end else if (hdr_latch[2:1] != 0 && body_pos == tend + 1) begin
                        r.byte_role = ROLE_PACKET_ID;
                        pkt_id = pkt_id | 16'(b);
                    end
                end
                body_pos = body_pos + 12'd1;
                if (body_pos >= rem_len)
                    r.packet_done = 1'b1;
            end
            default: begin
                // header stage, or an unused stage code: latch the header and await the length
                clear_parser();
                hdr_latch = b;
                pstage    = IN_LENGTH;
            end
        endcase

        is_pub = (hdr_latch[7:4] == TYPE_PUBLISH);
        r.packet_type          = hdr_latch[7:4];
        r.header_flags         = hdr_latch[3:0];
        r.publish_qos          = is_pub ? hdr_latch[2:1] : 2'd0;
        r.publish_topic_length = is_pub ? tpc_size : 16'd0;
        r.packet_identifier    = (is_pub && r.publish_qos != 0) ? pkt_id : 16'd0;
        if (r.packet_done && is_pub) begin
            if (rem_len < 2 || tpc_size > rem_len - 2 || tpc_size > cfg_topic_max ||
                (r.publish_qos != 0 && tpc_size + 4 > rem_len))
                r.publish_status = PUB_MALFORMED;
            else if (r.publish_qos == 0)
                r.publish_status = PUB_DELIVER;
            else if (r.publish_qos == 1)
                r.publish_status = (pkt_id != 0) ? PUB_PUBACK : PUB_DELIVER;
            else
                r.publish_status = PUB_UNSUPPORTED;
        end
        if (r.packet_done || r.frame_error != FERR_NONE)
            clear_parser();
        return r;
    endfunction

    function automatic int unsigned draw_wait(input logic [1:0] pace);
        case (pace)
            2'd0:    return 0;
            2'd1:    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, want, got);
        end
    endtask

    // Scoreboard: check result beats, predict accepted bytes, mirror register writes
    always @(posedge i_clk) begin
        t_result oldest;
        t_result fresh;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (!i_rst_n) begin
            clear_parser();
            cfg_body_max  = 12'd2048;
            cfg_topic_max = 11'd96;
            pending_beats.delete();
            tx_fire <= 1'b0;
            rx_fire <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_BODY:  cfg_body_max  = i_cfg_data;
                    CFG_MAX_TOPIC: cfg_topic_max = i_cfg_data[10:0];
                endcase
            end
            if (o_valid && !i_stall) begin
                if (pending_beats.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected beat, expected none, actual byte 0x%0h",
                             $time, o_data_byte);
                end else begin
                    oldest = pending_beats.pop_front();
                    compare_field("data_byte", oldest.data_byte, o_data_byte);
                    compare_field("byte_role", oldest.byte_role, o_byte_role);
                    compare_field("packet_type", oldest.packet_type, o_packet_type);
                    compare_field("header_flags", oldest.header_flags, o_header_flags);
                    compare_field("body_index", oldest.body_index, o_body_index);
                    compare_field("body_length", oldest.body_length, o_body_length);
                    compare_field("packet_done", oldest.packet_done, o_packet_done);
                    compare_field("frame_error", oldest.frame_error, o_frame_error);
                    compare_field("publish_qos", oldest.publish_qos, o_publish_qos);
                    compare_field("publish_topic_length", oldest.publish_topic_length,
                                  o_publish_topic_length);
                    compare_field("packet_identifier", oldest.packet_identifier,
                                  o_packet_identifier);
                    compare_field("publish_status", oldest.publish_status,
                                  o_publish_status);
                end
            end
            if (i_valid && !o_stall) begin
                fresh = deframe_byte(i_rx_byte);
                pending_beats.push_back(fresh);
                bytes_taken++;
                if (fresh.packet_done)
                    packets_closed++;
                if (fresh.frame_error != FERR_NONE)
                    frame_errors++;
                if (fresh.publish_status <= PUB_MALFORMED)
                    verdict_hits[fresh.publish_status]++;
            end
            tx_fire <= i_valid && !o_stall;
            rx_fire <= o_valid && !i_stall;
        end
    end

    // Byte driver: hold a beat until taken, then idle for the drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || tx_fire) begin
            if (tx_wait != 0) begin
                i_valid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end else if (tx_bytes.size() != 0) begin
                i_rx_byte <= tx_bytes.pop_front();
                i_valid   <= 1'b1;
                tx_wait   <= draw_wait(tx_pace);
                tx_sent   <= tx_sent + 1;
                if (tx_sent % 50 == 49)
                    tx_pace <= 2'($urandom_range(0, 2));
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: after each taken beat, stall for the drawn number of cycles
    always @(negedge i_clk) begin
        int unsigned stall_len;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait <= 0;
        end else if (rx_fire) begin
            stall_len = draw_wait(rx_pace);
            i_stall  <= (stall_len != 0);
            rx_wait  <= (stall_len != 0) ? stall_len - 1 : 0;
            rx_taken <= rx_taken + 1;
            if (rx_taken % 50 == 49)
                rx_pace <= 2'($urandom_range(0, 2));
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_random_bytes(input int unsigned n);
        repeat (n) push_byte(8'($urandom));
    endtask

    // Remaining length: 7 bits per byte, low group first, bit 7 set while more follow
    task automatic push_length(input int unsigned len);
        logic [7:0] d;
        do begin
            d   = 8'(len & 32'h7F);
            len = len >> 7;
            if (len != 0)
                d[7] = 1'b1;
            push_byte(d);
        end while (len != 0);
    endtask

    task automatic push_raw(input logic [7:0] hdr, input int unsigned len);
        push_byte(hdr);
        push_length(len);
        push_random_bytes(len);
    endtask

    task automatic push_publish(input logic [1:0] qos, input int unsigned tl,
                                input logic [15:0] id, input int unsigned payload);
        push_byte({TYPE_PUBLISH, 1'($urandom), qos, 1'($urandom)});
        push_length(2 + tl + ((qos != 0) ? 2 : 0) + payload);
        push_byte(tl[15:8]);
        push_byte(tl[7:0]);
        push_random_bytes(tl);
        if (qos != 0) begin
            push_byte(id[15:8]);
            push_byte(id[7:0]);
        end
        push_random_bytes(payload);
    endtask

    task automatic push_random_packet();
        int unsigned pick;
        int unsigned tl;
        int unsigned lim;
        logic [7:0]  hdr;
        pick = $urandom_range(0, 99);
        lim  = (cfg_body_max < BODY_LIMIT) ? cfg_body_max : BODY_LIMIT;
        hdr  = 8'($urandom);
        if (pick < 50) begin
            // well-formed PUBLISH, now and then right at or over the topic limit
            if (cfg_topic_max <= 40 && $urandom_range(0, 5) == 0)
                tl = cfg_topic_max + $urandom_range(0, 2);
            else
                tl = $urandom_range(0, 10);
            push_publish(2'($urandom), tl,
                         ($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom),
                         $urandom_range(0, 8));
        end else if (pick < 65) begin
            hdr[7:4] = TYPE_PUBLISH;
            push_raw(hdr, $urandom_range(0, 12));
        end else if (pick < 83) begin
            push_raw(hdr, ($urandom_range(0, 19) == 0) ? $urandom_range(128, 260)
                                                       : $urandom_range(0, 16));
        end else if (pick < 88) begin
            push_byte(hdr);
            repeat (4) push_byte(8'($urandom) | 8'h80);
        end else if (pick < 94) begin
            push_byte(hdr);
            push_length(($urandom_range(0, 3) == 0) ? $urandom_range(2097152, 268435455)
                                                    : lim + $urandom_range(1, 300));
            push_random_bytes($urandom_range(0, 4));
        end else begin
            push_random_bytes($urandom_range(1, 6));
        end
    endtask

    task automatic fill_random(input int unsigned n);
        int unsigned target;
        target = bytes_queued + n;
        while (bytes_queued < target)
            push_random_packet();
    endtask

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || i_valid || pending_beats.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        // ping, QoS 1 with id zero, short PUBLISH, overlong length, too long,
        // QoS 2 PUBLISH
        logic [7:0] opening [26] = '{
            8'hC0, 8'h00,
            8'h32, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h3F, 8'h01, 8'hFF,
            8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'h20, 8'h81, 8'h10,
            8'h34, 8'h05, 8'h00, 8'h01, 8'h41, 8'h12, 8'h34
        };
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[k])
            push_byte(opening[k]);
        wait_drained();

        write_reg(CFG_MAX_BODY, 12'd2048);
        write_reg(CFG_MAX_TOPIC, 12'd1024);
        fill_random(200);
        // long PUBLISH body with a two-byte length field, then one byte over the limit
        push_publish(2'd1, 5, 16'hBEEF, 160);
        push_byte(8'h30);
        push_length(2049);
        wait_drained();

        write_reg(CFG_MAX_BODY, 12'd0);
        write_reg(CFG_MAX_TOPIC, 12'd0);
        fill_random(80);
        wait_drained();

        write_reg(CFG_MAX_BODY, 12'($urandom_range(16, 300)));
        write_reg(CFG_MAX_TOPIC, 12'($urandom_range(0, 24)));
        fill_random(120);
        // pause the sender until every result is back
        wait_drained();
        fill_random(120);
        wait_drained();

        write_reg(CFG_MAX_BODY, 12'hFFF);
        write_reg(CFG_MAX_TOPIC, 12'h7FF);
        fill_random(120);
        wait_drained();

        repeat (8) @(posedge i_clk);
        $display("Run covered %0d bytes: %0d packets closed, %0d framing errors.",
                 bytes_taken, packets_closed, frame_errors);
        $display("PUBLISH verdicts: deliver %0d, puback %0d, unsupported QoS %0d, malformed %0d.",
                 verdict_hits[PUB_DELIVER], verdict_hits[PUB_PUBACK],
                 verdict_hits[PUB_UNSUPPORTED], verdict_hits[PUB_MALFORMED]);
        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
